// ===== design/lppoc_pkg.sv =====
// Shared types and constants for the long-press power-off controller.
`default_nettype none

package lppoc_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DEBOUNCE_MS   = 2'd0;
   localparam logic [1:0] CSR_HOLD_MS       = 2'd1;
   localparam logic [1:0] CSR_INDICATION_MS = 2'd2;
   localparam logic [1:0] CSR_PRESS_LEVEL   = 2'd3;

   // Configuration reset values.
   localparam logic [7:0]  DEBOUNCE_MS_RESET   = 8'd50;
   localparam logic [15:0] HOLD_MS_RESET       = 16'd3000;
   localparam logic [15:0] INDICATION_MS_RESET = 16'd800;
   localparam logic        PRESS_LEVEL_RESET   = 1'b0;

   // Raw level of a released button with its pull-up.
   localparam logic RAW_RESET = 1'b1;

   typedef enum logic [1:0] {
      MODE_NORMAL     = 2'd0,
      MODE_HOLDING    = 2'd1,
      MODE_INDICATING = 2'd2,
      MODE_OFF        = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      EVT_NONE    = 2'd0,
      EVT_PRESS   = 2'd1,
      EVT_RELEASE = 2'd2
   } event_type;

   // Configuration as seen by the step logic.
   typedef struct packed {
      logic [7:0]  debounce_ms;
      logic [15:0] hold_ms;
      logic [15:0] indication_ms;
      logic        press_level;
   } cfg_type;

   // Controller state carried from tick to tick.
   typedef struct packed {
      logic        last_raw;
      logic        debounce_busy;
      logic [7:0]  debounce_left;
      mode_type    power_mode;
      logic [15:0] timer_left;
      logic        timer_running;
   } state_type;

   // One result beat.
   typedef struct packed {
      mode_type  mode;
      event_type button_event;
      logic      blink_start;
      logic      shutdown_now;
   } result_type;

endpackage

`default_nettype wire

// ===== design/lppoc_step.sv =====
// Next-state and result logic for one millisecond tick of the controller.
`default_nettype none

module lppoc_step (
   input  var lppoc_pkg::cfg_type    cfg,
   input  var lppoc_pkg::state_type  state_cur,
   input  wire logic                 button_raw,
   output lppoc_pkg::state_type      state_nxt,
   output lppoc_pkg::result_type     result
);

   logic [15:0]          timer_dec;
   logic [7:0]           debounce_dec;
   lppoc_pkg::event_type evt;
   logic                 blink;
   logic                 shut;
   lppoc_pkg::state_type s;

   assign timer_dec    = (state_cur.timer_left != 16'd0) ?
                         state_cur.timer_left - 16'd1 : 16'd0;
   assign debounce_dec = (state_cur.debounce_left != 8'd0) ?
                         state_cur.debounce_left - 8'd1 : 8'd0;

   always_comb begin
      s     = state_cur;
      evt   = lppoc_pkg::EVT_NONE;
      blink = 1'b0;
      shut  = 1'b0;

      // The power timer counts down first; expiry while indicating powers off.
      if (state_cur.timer_running) begin
         s.timer_left = timer_dec;
         if (timer_dec == 16'd0) begin
            s.timer_running = 1'b0;
            if (state_cur.power_mode == lppoc_pkg::MODE_INDICATING) begin
               s.power_mode = lppoc_pkg::MODE_OFF;
               shut         = 1'b1;
            end
         end
      end

      // Debouncer: sample at the end of a window, or open one on a change.
      if (state_cur.debounce_busy) begin
         s.debounce_left = debounce_dec;
         if (debounce_dec == 8'd0) begin
            s.debounce_busy = 1'b0;
            evt = (button_raw == cfg.press_level) ? lppoc_pkg::EVT_PRESS
                                                  : lppoc_pkg::EVT_RELEASE;
         end
      end else if (button_raw != state_cur.last_raw) begin
         s.debounce_busy = 1'b1;
         s.debounce_left = (cfg.debounce_ms != 8'd0) ? cfg.debounce_ms : 8'd1;
      end
      s.last_raw = button_raw;

      // Mode logic on the debounced event of this tick.
      case (evt)
         lppoc_pkg::EVT_PRESS: begin
            if (s.power_mode == lppoc_pkg::MODE_NORMAL) begin
               s.timer_left    = (cfg.hold_ms != 16'd0) ? cfg.hold_ms : 16'd1;
               s.timer_running = 1'b1;
               s.power_mode    = lppoc_pkg::MODE_HOLDING;
            end
         end
         lppoc_pkg::EVT_RELEASE: begin
            if (s.power_mode == lppoc_pkg::MODE_HOLDING) begin
               if (s.timer_running) begin
                  // Released too early: abort.
                  s.timer_running = 1'b0;
                  s.timer_left    = 16'd0;
                  s.power_mode    = lppoc_pkg::MODE_NORMAL;
               end else begin
                  blink           = 1'b1;
                  s.timer_left    = (cfg.indication_ms != 16'd0) ?
                                    cfg.indication_ms : 16'd1;
                  s.timer_running = 1'b1;
                  s.power_mode    = lppoc_pkg::MODE_INDICATING;
               end
            end
         end
         default: begin
         end
      endcase

      state_nxt           = s;
      result.mode         = s.power_mode;
      result.button_event = evt;
      result.blink_start  = blink;
      result.shutdown_now = shut;
   end

endmodule

`default_nettype wire

// ===== design/long_press_power_off_controller_top.sv =====
// Top level of the long-press power-off controller with button debounce.
`default_nettype none

// Each request beat is one millisecond tick carrying the raw button level, and
// each one produces exactly one response beat with the mode after that tick,
// the debounced button event and the blink and shutdown pulses. The controller
// state and the response register update on the edge that accepts the beat,
// so a new tick can be taken every cycle as long as the response register is
// empty or being emptied in the same cycle. The response is registered and
// appears in the cycle after the request is accepted. Configuration
// registers reset to debounce 50, hold 3000, indication 800 and press level 0;
// write them only while no tick is in flight.
module long_press_power_off_controller_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration write port.
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data,
   // Request channel.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_button_raw,
   // Response channel.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_mode,
   output logic [1:0]       rsp_button_event,
   output logic             rsp_blink_start,
   output logic             rsp_shutdown_now
);

   lppoc_pkg::cfg_type    cfg_ff;
   lppoc_pkg::state_type  state_ff;
   lppoc_pkg::state_type  state_in;
   lppoc_pkg::result_type result_ff;
   lppoc_pkg::result_type result_in;
   logic                  rsp_valid_ff;
   logic                  req_accept;

   // The response register can take a new beat when it is empty or draining.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   lppoc_step u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .button_raw (req_button_raw),
      .state_nxt  (state_in),
      .result     (result_in)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= lppoc_pkg::DEBOUNCE_MS_RESET;
         cfg_ff.hold_ms       <= lppoc_pkg::HOLD_MS_RESET;
         cfg_ff.indication_ms <= lppoc_pkg::INDICATION_MS_RESET;
         cfg_ff.press_level   <= lppoc_pkg::PRESS_LEVEL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lppoc_pkg::CSR_DEBOUNCE_MS:   cfg_ff.debounce_ms   <= csr_write_data[7:0];
            lppoc_pkg::CSR_HOLD_MS:       cfg_ff.hold_ms       <= csr_write_data;
            lppoc_pkg::CSR_INDICATION_MS: cfg_ff.indication_ms <= csr_write_data;
            lppoc_pkg::CSR_PRESS_LEVEL:   cfg_ff.press_level   <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Controller state advances once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.last_raw      <= lppoc_pkg::RAW_RESET;
         state_ff.debounce_busy <= 1'b0;
         state_ff.debounce_left <= 8'd0;
         state_ff.power_mode    <= lppoc_pkg::MODE_NORMAL;
         state_ff.timer_left    <= 16'd0;
         state_ff.timer_running <= 1'b0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Response register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode         = result_ff.mode;
   assign rsp_button_event = result_ff.button_event;
   assign rsp_blink_start  = result_ff.blink_start;
   assign rsp_shutdown_now = result_ff.shutdown_now;

endmodule

`default_nettype wire
